// ===== src/svap_pkg.sv =====
// Package for the voice allocator: channel record, codes and default sizes.
package svap_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam logic [3:0] ACTIVE_CHANNELS_RST = 4'd8;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_STOLEN  = 3'd1;
  localparam logic [2:0] ST_LOOP    = 3'd2;
  localparam logic [2:0] ST_LIMIT   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  localparam logic signed [4:0] LIMIT_NONE = -5'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_SCAN2,
    S_SCAN3,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        active;
    logic [15:0] origin;
    logic [8:0]  sound;
    logic [11:0] prio;
    logic        loop;
    logic [15:0] timeout;
  } chan_t;

endpackage

// ===== src/sound_voice_allocator_priority.sv =====
// Top level of the voice allocator: channel ring of cells and its scan sequencer.
//
// The channel table lives in a ring of NUM_CHANNELS cells. While a request is
// worked on, the ring rotates by one cell every cycle, and the sequencer looks at
// and updates the record at the head cell. One full turn of the ring is one scan.
// Raise start while busy is low; the request is taken at that edge. A stop or
// release request takes one scan. A start request takes one scan when the sound
// limit refuses it, two when a looping duplicate is refreshed or no channel can
// be had, and three when a channel is granted. The result appears in the cycle
// after the last scan, on out_valid for exactly one cycle. Busy stays high while
// the result is shown and drops when the sequencer then returns to idle. The
// receiver cannot stall the result, so it must take it in the strobe cycle.
// cfg_we writes the number of channels in use; values above NUM_CHANNELS act as
// NUM_CHANNELS, and the register is to be written only while busy is low.
module sound_voice_allocator_priority #(
  parameter int NUM_CHANNELS = svap_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_origin_id,
  input  logic [8:0]  in_sound_id,
  input  logic [11:0] in_priority_req,
  input  logic signed [4:0] in_sound_limit,
  input  logic        in_from_listener,
  input  logic        in_in_level,
  input  logic [15:0] in_loop_time,
  input  logic [2:0]  in_release_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [2:0]  out_granted_channel,
  output logic [7:0]  out_stopped_mask
);
  import svap_pkg::*;

  localparam int IW = $clog2(NUM_CHANNELS);
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(NUM_CHANNELS - 1);

  // Ring of channel cells; cell 0 is the head.
  chan_t cell_q [NUM_CHANNELS];
  chan_t head_mod;
  logic  shift;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_ring
      if (gi == NUM_CHANNELS - 1) begin : g_tail
        svap_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                          .d(head_mod), .q(cell_q[gi]));
      end else begin : g_mid
        svap_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                          .d(cell_q[gi+1]), .q(cell_q[gi]));
      end
    end
  endgenerate

  // Control and request registers.
  state_t state_r, state_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [3:0]  cfg_r, cfg_nxt;
  logic [IW-1:0] rs_r, rs_nxt;

  logic [1:0]  kind_r;
  logic [15:0] org_r;
  logic [8:0]  snd_r;
  logic [11:0] prio_r;
  logic signed [4:0] lim_r;
  logic        lis_r, lvl_r;
  logic [15:0] ltime_r;
  logic [2:0]  rel_r;

  logic [NUM_CHANNELS-1:0] mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;

  // Scan statistics.
  logic          dup_f_r, dup_f_nxt;
  logic [IW-1:0] dup_idx_r, dup_idx_nxt;
  logic [CW-1:0] found_r, found_nxt;
  logic [11:0]   best_r, best_nxt;
  logic          weak_f_r, weak_f_nxt;
  logic [IW-1:0] weak_idx_r, weak_idx_nxt;
  logic          weak_do_r, weak_do_nxt;
  logic          org_f_r, org_f_nxt;
  logic [IW-1:0] org_idx_r, org_idx_nxt;
  logic          oact_f_r, oact_f_nxt;
  logic [IW-1:0] oact_idx_r, oact_idx_nxt;
  logic          free_f_r, free_f_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          hi_f_r, hi_f_nxt, hi_act_r, hi_act_nxt;
  logic [IW-1:0] hi_idx_r, hi_idx_nxt;
  logic          lo_f_r, lo_f_nxt, lo_act_r, lo_act_nxt;
  logic [IW-1:0] lo_idx_r, lo_idx_nxt;

  // Decisions for the third scan.
  logic          refresh_r, refresh_nxt;
  logic          wr_en_r, wr_en_nxt;
  logic [IW-1:0] grant_r, grant_nxt;
  logic          halt_en_r, halt_en_nxt;
  logic [IW-1:0] halt_idx_r, halt_idx_nxt;

  logic          go_scan2, go_scan3;

  // Channel count and rotation start.
  logic [CW-1:0] n_used;
  logic [CW:0]   rs_inc;
  logic [IW-1:0] rs_new;
  logic          in_rng, last, accept, want_loop, a_eff;
  logic signed [6:0] found_s, lim_s;
  logic          reached;
  logic [2:0]    rel_pos;

  assign accept    = start && (state_r == S_IDLE);
  assign last      = (pos_r == LAST_POS);
  assign want_loop = (ltime_r != 16'd0);
  assign rel_pos   = 3'(pos_r);

  always_comb begin
    if (32'(cfg_r) > NUM_CHANNELS) begin
      n_used = CW'(NUM_CHANNELS);
    end else begin
      n_used = CW'(cfg_r);
    end
    rs_inc = (CW+1)'(rs_r) + (CW+1)'(1);
    rs_new = (rs_inc >= (CW+1)'(n_used)) ? '0 : IW'(rs_inc);
    in_rng = (CW'(pos_r) < n_used);
  end

  // Head cell processing and statistics.
  always_comb begin
    head_mod     = cell_q[0];
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    rs_nxt       = rs_r;
    dup_f_nxt    = dup_f_r;
    dup_idx_nxt  = dup_idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    weak_f_nxt   = weak_f_r;
    weak_idx_nxt = weak_idx_r;
    weak_do_nxt  = weak_do_r;
    org_f_nxt    = org_f_r;
    org_idx_nxt  = org_idx_r;
    oact_f_nxt   = oact_f_r;
    oact_idx_nxt = oact_idx_r;
    free_f_nxt   = free_f_r;
    free_idx_nxt = free_idx_r;
    hi_f_nxt     = hi_f_r;
    hi_idx_nxt   = hi_idx_r;
    hi_act_nxt   = hi_act_r;
    lo_f_nxt     = lo_f_r;
    lo_idx_nxt   = lo_idx_r;
    lo_act_nxt   = lo_act_r;
    refresh_nxt  = refresh_r;
    wr_en_nxt    = wr_en_r;
    grant_nxt    = grant_r;
    halt_en_nxt  = halt_en_r;
    halt_idx_nxt = halt_idx_r;
    go_scan2     = 1'b0;
    go_scan3     = 1'b0;
    found_s      = '0;
    lim_s        = '0;
    reached      = 1'b0;
    a_eff        = cell_q[0].active;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mask_nxt    = '0;
          status_nxt  = ST_DONE;
          dup_f_nxt   = 1'b0;
          found_nxt   = '0;
          best_nxt    = in_priority_req;
          weak_f_nxt  = 1'b0;
          weak_do_nxt = 1'b0;
          org_f_nxt   = 1'b0;
          oact_f_nxt  = 1'b0;
          free_f_nxt  = 1'b0;
          hi_f_nxt    = 1'b0;
          lo_f_nxt    = 1'b0;
          refresh_nxt = 1'b0;
          wr_en_nxt   = 1'b0;
          halt_en_nxt = 1'b0;
        end
      end
      S_SCAN1: begin
        if (kind_r == KIND_STOP) begin
          if (in_rng && cell_q[0].active && cell_q[0].origin == org_r) begin
            head_mod.active = 1'b0;
            mask_nxt[pos_r] = 1'b1;
          end
        end else if (kind_r == KIND_RELEASE) begin
          if (in_rng && rel_pos == rel_r && 32'(pos_r) == 32'(rel_r)
              && cell_q[0].active) begin
            head_mod.active = 1'b0;
            mask_nxt[pos_r] = 1'b1;
          end
        end else if (kind_r == KIND_START) begin
          if (in_rng && cell_q[0].active && cell_q[0].sound == snd_r) begin
            if (cell_q[0].origin == org_r && cell_q[0].loop && want_loop
                && !dup_f_r) begin
              dup_f_nxt   = 1'b1;
              dup_idx_nxt = pos_r;
            end
            found_nxt = found_r + CW'(1);
            if (best_r >= cell_q[0].prio
                && (!cell_q[0].loop || best_r > cell_q[0].prio)) begin
              weak_f_nxt   = 1'b1;
              weak_idx_nxt = pos_r;
              best_nxt     = cell_q[0].prio;
            end
          end
          if (last) begin
            found_s = 7'(found_nxt);
            lim_s   = {{2{lim_r[4]}}, lim_r};
            reached = (lim_r != LIMIT_NONE) && (found_s >= lim_s);
            if (dup_f_nxt) begin
              refresh_nxt = 1'b1;
              grant_nxt   = dup_idx_nxt;
              status_nxt  = ST_LOOP;
              go_scan3    = 1'b1;
            end else if (reached && !weak_f_nxt) begin
              status_nxt = ST_LIMIT;
            end else begin
              weak_do_nxt = reached;
              go_scan2    = 1'b1;
            end
          end
        end
      end
      S_SCAN2: begin
        if (weak_do_r && pos_r == weak_idx_r && cell_q[0].active) begin
          head_mod.active = 1'b0;
          mask_nxt[pos_r] = 1'b1;
        end
        a_eff = head_mod.active;
        if (in_rng) begin
          if (cell_q[0].origin == org_r) begin
            if (!org_f_r) begin
              org_f_nxt   = 1'b1;
              org_idx_nxt = pos_r;
            end
            if (a_eff && !oact_f_r) begin
              oact_f_nxt   = 1'b1;
              oact_idx_nxt = pos_r;
            end
          end
          if (!a_eff && !free_f_r) begin
            free_f_nxt   = 1'b1;
            free_idx_nxt = pos_r;
          end
          if (prio_r >= cell_q[0].prio) begin
            if (pos_r >= rs_new) begin
              if (!hi_f_r) begin
                hi_f_nxt   = 1'b1;
                hi_idx_nxt = pos_r;
                hi_act_nxt = a_eff;
              end
            end else if (!lo_f_r) begin
              lo_f_nxt   = 1'b1;
              lo_idx_nxt = pos_r;
              lo_act_nxt = a_eff;
            end
          end
        end
        if (last) begin
          if (lvl_r && !lis_r && org_f_nxt) begin
            // Takeover of the origin's channel; its first active channel stops.
            grant_nxt    = org_idx_nxt;
            halt_en_nxt  = oact_f_nxt;
            halt_idx_nxt = oact_idx_nxt;
            wr_en_nxt    = 1'b1;
            status_nxt   = oact_f_nxt ? ST_STOLEN : ST_FREE;
            go_scan3     = 1'b1;
          end else if (free_f_nxt) begin
            grant_nxt  = free_idx_nxt;
            wr_en_nxt  = 1'b1;
            status_nxt = ST_FREE;
            go_scan3   = 1'b1;
          end else begin
            rs_nxt = rs_new;
            if (hi_f_nxt || lo_f_nxt) begin
              grant_nxt    = hi_f_nxt ? hi_idx_nxt : lo_idx_nxt;
              halt_en_nxt  = 1'b1;
              halt_idx_nxt = hi_f_nxt ? hi_idx_nxt : lo_idx_nxt;
              wr_en_nxt    = 1'b1;
              status_nxt   = (hi_f_nxt ? hi_act_nxt : lo_act_nxt) ? ST_STOLEN : ST_FREE;
              go_scan3     = 1'b1;
            end else begin
              status_nxt = ST_FULL;
            end
          end
        end
      end
      S_SCAN3: begin
        if (refresh_r) begin
          if (pos_r == grant_r) begin
            head_mod.timeout = ltime_r;
          end
        end else begin
          if (halt_en_r && pos_r == halt_idx_r && cell_q[0].active) begin
            head_mod.active = 1'b0;
            mask_nxt[pos_r] = 1'b1;
          end
          if (wr_en_r && pos_r == grant_r) begin
            head_mod.active  = 1'b1;
            head_mod.origin  = org_r;
            head_mod.sound   = snd_r;
            head_mod.prio    = prio_r;
            head_mod.loop    = want_loop;
            head_mod.timeout = ltime_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN1;
      S_SCAN1: begin
        if (last) begin
          if (go_scan3) begin
            state_nxt = S_SCAN3;
          end else if (go_scan2) begin
            state_nxt = S_SCAN2;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN2: if (last) state_nxt = go_scan3 ? S_SCAN3 : S_DONE;
      S_SCAN3: if (last) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and ring control.
  logic [IW+2:0] grant_ext;
  always_comb begin
    shift     = 1'b0;
    busy      = 1'b1;
    out_valid = 1'b0;
    grant_ext = (IW+3)'(grant_r);
    out_status = status_r;
    out_granted_channel = (status_r == ST_FREE || status_r == ST_STOLEN) ?
                          grant_ext[2:0] : 3'd0;
    case (state_r)
      S_IDLE:  busy = 1'b0;
      S_SCAN1, S_SCAN2, S_SCAN3: shift = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  generate
    for (gi = 0; gi < 8; gi++) begin : g_mask
      if (gi < NUM_CHANNELS) begin : g_on
        assign out_stopped_mask[gi] = mask_r[gi];
      end else begin : g_off
        assign out_stopped_mask[gi] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    pos_nxt = shift ? (last ? '0 : pos_r + IW'(1)) : pos_r;
    cfg_nxt = cfg_we ? cfg_wdata : cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      cfg_r   <= ACTIVE_CHANNELS_RST;
      rs_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cfg_r   <= cfg_nxt;
      rs_r    <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      org_r   <= in_origin_id;
      snd_r   <= in_sound_id;
      prio_r  <= in_priority_req;
      lim_r   <= in_sound_limit;
      lis_r   <= in_from_listener;
      lvl_r   <= in_in_level;
      ltime_r <= in_loop_time;
      rel_r   <= in_release_index;
    end
    mask_r     <= mask_nxt;
    status_r   <= status_nxt;
    dup_f_r    <= dup_f_nxt;
    dup_idx_r  <= dup_idx_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    weak_f_r   <= weak_f_nxt;
    weak_idx_r <= weak_idx_nxt;
    weak_do_r  <= weak_do_nxt;
    org_f_r    <= org_f_nxt;
    org_idx_r  <= org_idx_nxt;
    oact_f_r   <= oact_f_nxt;
    oact_idx_r <= oact_idx_nxt;
    free_f_r   <= free_f_nxt;
    free_idx_r <= free_idx_nxt;
    hi_f_r     <= hi_f_nxt;
    hi_idx_r   <= hi_idx_nxt;
    hi_act_r   <= hi_act_nxt;
    lo_f_r     <= lo_f_nxt;
    lo_idx_r   <= lo_idx_nxt;
    lo_act_r   <= lo_act_nxt;
    refresh_r  <= refresh_nxt;
    wr_en_r    <= wr_en_nxt;
    grant_r    <= grant_nxt;
    halt_en_r  <= halt_en_nxt;
    halt_idx_r <= halt_idx_nxt;
  end

`ifndef NO_ASSERTIONS
  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  // A refused or non-start result carries no channel.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FREE && out_status != ST_STOLEN
    |-> out_granted_channel == 3'd0) else $error("channel on refused result");
  // Busy drops only right after a result.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid)) else $error("busy fell without result");
  // A taken request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  // The ring is home whenever the block is idle.
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> pos_r == '0) else $error("ring out of place");
`endif

endmodule

// ===== src/svap_cell.sv =====
// One channel cell: holds a channel record and passes it to its neighbor on each shift.
module svap_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  svap_pkg::chan_t d,
  output svap_pkg::chan_t q
);
  import svap_pkg::*;

  chan_t rec_r;
  chan_t rec_nxt;

  always_comb begin
    rec_nxt = shift ? d : rec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign q = rec_r;

endmodule
